// ===== rtl/krwc_pkg.sv =====
// ----------------------------------------------------------------------------
// krwc_pkg
// Shared widths, constants, register indexes and helper functions for the
// RTT window control block and its arithmetic units.
// ----------------------------------------------------------------------------
package krwc_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS  = 16;
   localparam int RTT_BITS   = 20;
   localparam int CW_BITS    = 32;
   localparam int SEG_BITS   = 16;
   localparam int EST_BITS   = 56;
   localparam int PRED_BITS  = 36;
   localparam int NOISE_BITS = 24;
   localparam int ALPHA_BITS = 17;
   localparam int RATIO_BITS = 19;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   // shared multiplier: 56x56 built from four 28x28 partial products
   localparam int HALF_W    = EST_BITS / 2;
   localparam int PROD_BITS = 2 * EST_BITS;

   // shared divider
   localparam int DVD_BITS  = 36;
   localparam int DVS_BITS  = 48;
   localparam int ITER_BITS = 6;
   localparam int GAIN_BITS = FRAC_BITS + 1;

   // window cut: floor(x/10) = (x * RECIP10) >> CUT_SHIFT, exact for x < 2^38
   localparam int CUT_SHIFT = 39;
   localparam logic [EST_BITS-1:0] RECIP10 =
      EST_BITS'(((64'd1 << CUT_SHIFT) + 64'd9) / 64'd10);

   localparam logic [EST_BITS-1:0]  CAP56   = '1;
   localparam logic [GAIN_BITS-1:0] ONE_Q   = GAIN_BITS'(1 << FRAC_BITS);
   localparam logic [EST_BITS-1:0]  HALF_Q  = EST_BITS'(1 << (FRAC_BITS - 1));
   localparam logic [EST_BITS-1:0]  TENTH_Q = EST_BITS'(((1 << FRAC_BITS) + 5) / 10);

   // configuration register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PROCESS_NOISE   = 3'd0,
      CSR_INITIAL_NOISE   = 3'd1,
      CSR_ADAPTIVE_ENABLE = 3'd2,
      CSR_ADAPT_ALPHA     = 3'd3,
      CSR_RATIO_THRESHOLD = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                start;
      logic [EST_BITS-1:0] a;
      logic [EST_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                 done;
      logic [PROD_BITS-1:0] prod;
   } mul_rsp_type;

   typedef struct packed {
      logic                 start;
      logic [DVS_BITS-1:0]  rem_init;
      logic [DVD_BITS-1:0]  dvd;
      logic [DVS_BITS-1:0]  dvs;
      logic [ITER_BITS-1:0] iters;
   } div_req_type;

   typedef struct packed {
      logic                done;
      logic [DVD_BITS-1:0] quo;
   } div_rsp_type;

   // floor(product / 2^F), saturated to 56 bits
   function automatic logic [EST_BITS-1:0] mul_q_sat(input logic [PROD_BITS-1:0] p);
      logic [EST_BITS-1:0] r;
      if (|p[PROD_BITS-1:EST_BITS+FRAC_BITS]) begin
         r = CAP56;
      end else begin
         r = p[EST_BITS+FRAC_BITS-1:FRAC_BITS];
      end
      return r;
   endfunction

   function automatic logic [EST_BITS-1:0] sat56(input logic [EST_BITS:0] v);
      return v[EST_BITS] ? CAP56 : v[EST_BITS-1:0];
   endfunction

endpackage

// ===== rtl/kalman_rtt_window_control.sv =====
// ----------------------------------------------------------------------------
// kalman_rtt_window_control
// RTT-driven congestion window control with a scalar Kalman RTT estimate.
// ----------------------------------------------------------------------------
// One word is taken at a time; req_ready is high only while the sequencer
// is idle. A zero-sample ACK, a slow-start window word and the first sample
// go straight to the output load. A filter update takes five multiplier
// passes and a 17-step gain division with adaptive noise, and two passes and
// the division without; a congestion-avoidance word takes a ratio product
// and then a reciprocal product for the divide by ten when the window is cut,
// the ratio product, a square and then a 32-step divide when it grows, and
// the square and the divide when it grows before the first sample. Each
// multiplier pass runs through a request register, a load, four partial
// products, an accumulate and a return. A finished result waits in the rsp_
// output register; the next word is accepted meanwhile and only the final
// load waits on rsp_ready.
// ----------------------------------------------------------------------------
module kalman_rtt_window_control import krwc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_func,
   input  logic [RTT_BITS-1:0]      req_rtt_ms,
   input  logic [CW_BITS-1:0]       req_cwnd,
   input  logic [CW_BITS-1:0]       req_ssthresh,
   input  logic [SEG_BITS-1:0]      req_segment_size,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [CW_BITS-1:0]       rsp_new_cwnd,
   output logic [PRED_BITS-1:0]     rsp_predicted_rtt,
   output logic [RTT_BITS-1:0]      rsp_base_rtt_ms,
   output logic                     rsp_window_cut,
   output logic                     rsp_sample_taken,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PREP, ST_SQ, ST_T1, ST_T2, ST_NOISE, ST_NORM, ST_GAIN,
      ST_DELTA, ST_COV, ST_RATIO, ST_CUT, ST_GROW, ST_GROW_DIV, ST_WAIT, ST_FINISH
   } state_type;

   state_type state_ff, ret_ff;

   // configuration
   logic [NOISE_BITS-1:0] q_noise_ff, init_noise_ff;
   logic                  adapt_en_ff;
   logic [ALPHA_BITS-1:0] alpha_ff;
   logic [RATIO_BITS-1:0] ratio_ff;

   // filter state
   logic                started_ff;
   logic [EST_BITS-1:0] est_ff, cov_ff, noise_ff, ia_ff;
   logic [RTT_BITS-1:0] min_ff;

   // per-word working registers
   logic [RTT_BITS-1:0]  z_ff;
   logic [CW_BITS-1:0]   cw_ff, ncw_ff;
   logic [SEG_BITS-1:0]  seg_ff;
   logic [EST_BITS-1:0]  pp_ff, mag_ff, t1_ff;
   logic                 neg_ff, cut_ff, taken_ff;
   logic [GAIN_BITS-1:0] gain_ff;

   // output register
   logic                 rsp_valid_ff, rsp_cut_ff, rsp_taken_ff;
   logic [CW_BITS-1:0]   rsp_cwnd_ff;
   logic [PRED_BITS-1:0] rsp_pred_ff;
   logic [RTT_BITS-1:0]  rsp_base_ff;

   mul_req_type mul_req_ff;
   mul_rsp_type mul_rsp;
   div_req_type div_req_ff;
   div_rsp_type div_rsp;

   krwc_mul u_mul (.clock(clock), .reset(reset), .req(mul_req_ff), .rsp(mul_rsp));
   krwc_div u_div (.clock(clock), .reset(reset), .req(div_req_ff), .rsp(div_rsp));

   // datapath around the shared units
   logic [EST_BITS-1:0]   pp_c, zq_c, mag_c, mulq_c, ia_sum_c, est_r_c, est_upd_c;
   logic [EST_BITS-1:0]   est_add_c, est_sub_c, num_s_c;
   logic                  neg_c;
   logic [GAIN_BITS-1:0]  a_clamp_c, oma_c, omg_c, gain_c;
   logic [EST_BITS:0]     den_c, den_s_c;
   logic [3:0]            k_c;
   logic [CW_BITS:0]      ss_sum_c, grow_sum_c;
   logic [CW_BITS-1:0]    req_ss_cwnd_c, grow_cwnd_c, cw_div_c;
   logic                  accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      pp_c   = sat56({1'b0, cov_ff} + (EST_BITS+1)'(q_noise_ff));
      zq_c   = EST_BITS'({z_ff, FRAC_BITS'(0)});
      neg_c  = zq_c < est_ff;
      mag_c  = neg_c ? est_ff - zq_c : zq_c - est_ff;
      mulq_c = mul_q_sat(mul_rsp.prod);

      a_clamp_c = (alpha_ff > ONE_Q) ? ONE_Q : alpha_ff;
      oma_c     = ONE_Q - a_clamp_c;
      ia_sum_c  = sat56({1'b0, t1_ff} + {1'b0, mulq_c});
      est_r_c   = (ia_ff > pp_ff) ? ia_ff - pp_ff : '0;
      if (est_r_c < HALF_Q) begin
         est_r_c = HALF_Q;
      end

      // bring the gain denominator below 2^47
      den_c = {1'b0, pp_ff} + {1'b0, noise_ff};
      k_c   = '0;
      for (int i = 0; i < 10; i++) begin
         if (den_c[DVS_BITS-1+i]) begin
            k_c = 4'(i + 1);
         end
      end
      num_s_c = pp_ff >> k_c;
      den_s_c = den_c >> k_c;

      gain_c = ((|div_rsp.quo[DVD_BITS-1:GAIN_BITS]) || (div_rsp.quo[GAIN_BITS-1:0] > ONE_Q))
               ? ONE_Q : div_rsp.quo[GAIN_BITS-1:0];
      omg_c  = ONE_Q - gain_ff;

      // estimate correction, floored at one tenth
      est_add_c = sat56({1'b0, est_ff} + {1'b0, mulq_c});
      est_sub_c = (mulq_c > est_ff) ? '0 : est_ff - mulq_c;
      est_upd_c = neg_ff ? est_sub_c : est_add_c;
      if (est_upd_c < TENTH_Q) begin
         est_upd_c = TENTH_Q;
      end

      ss_sum_c      = {1'b0, req_cwnd} + (CW_BITS+1)'(req_segment_size);
      req_ss_cwnd_c = ss_sum_c[CW_BITS] ? '1 : ss_sum_c[CW_BITS-1:0];
      grow_sum_c    = {1'b0, cw_ff} + {1'b0, div_rsp.quo[CW_BITS-1:0]};
      grow_cwnd_c   = grow_sum_c[CW_BITS] ? '1 : grow_sum_c[CW_BITS-1:0];
      cw_div_c      = (cw_ff == '0) ? CW_BITS'(1) : cw_ff;
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         q_noise_ff    <= NOISE_BITS'(65536);
         init_noise_ff <= NOISE_BITS'(655360);
         adapt_en_ff   <= 1'b1;
         alpha_ff      <= ALPHA_BITS'(6554);
         ratio_ff      <= RATIO_BITS'(81920);
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROCESS_NOISE:   q_noise_ff    <= csr_wdata;
            CSR_INITIAL_NOISE:   init_noise_ff <= csr_wdata;
            CSR_ADAPTIVE_ENABLE: adapt_en_ff   <= csr_wdata[0];
            CSR_ADAPT_ALPHA:     alpha_ff      <= csr_wdata[ALPHA_BITS-1:0];
            CSR_RATIO_THRESHOLD: ratio_ff      <= csr_wdata[RATIO_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         ret_ff           <= ST_IDLE;
         started_ff       <= 1'b0;
         est_ff           <= '0;
         cov_ff           <= '0;
         noise_ff         <= '0;
         ia_ff            <= '0;
         min_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  z_ff     <= req_rtt_ms;
                  cw_ff    <= req_cwnd;
                  seg_ff   <= req_segment_size;
                  ncw_ff   <= req_cwnd;
                  cut_ff   <= 1'b0;
                  taken_ff <= 1'b0;
                  state_ff <= ST_FINISH;
                  if (!req_func) begin
                     if (req_rtt_ms != '0) begin
                        taken_ff <= 1'b1;
                        if (min_ff == '0 || req_rtt_ms < min_ff) begin
                           min_ff <= req_rtt_ms;
                        end
                        if (!started_ff) begin
                           est_ff     <= EST_BITS'({req_rtt_ms, FRAC_BITS'(0)});
                           noise_ff   <= EST_BITS'(init_noise_ff);
                           cov_ff     <= EST_BITS'(init_noise_ff);
                           ia_ff      <= '0;
                           started_ff <= 1'b1;
                        end else begin
                           state_ff <= ST_PREP;
                        end
                     end
                  end else if (req_cwnd < req_ssthresh) begin
                     ncw_ff <= req_ss_cwnd_c;
                  end else if (started_ff && min_ff != '0) begin
                     mul_req_ff <= '{1'b1, EST_BITS'(ratio_ff), EST_BITS'(min_ff)};
                     ret_ff     <= ST_RATIO;
                     state_ff   <= ST_WAIT;
                  end else begin
                     mul_req_ff <= '{1'b1, EST_BITS'(req_segment_size),
                                     EST_BITS'(req_segment_size)};
                     ret_ff     <= ST_GROW;
                     state_ff   <= ST_WAIT;
                  end
               end
            end
            // prior covariance and innovation
            ST_PREP: begin
               pp_ff  <= pp_c;
               neg_ff <= neg_c;
               mag_ff <= mag_c;
               if (adapt_en_ff) begin
                  mul_req_ff <= '{1'b1, mag_c, mag_c};
                  ret_ff     <= ST_SQ;
                  state_ff   <= ST_WAIT;
               end else begin
                  state_ff <= ST_NORM;
               end
            end
            ST_SQ: begin
               mul_req_ff <= '{1'b1, EST_BITS'(a_clamp_c), mulq_c};
               ret_ff     <= ST_T1;
               state_ff   <= ST_WAIT;
            end
            ST_T1: begin
               t1_ff      <= mulq_c;
               mul_req_ff <= '{1'b1, EST_BITS'(oma_c), ia_ff};
               ret_ff     <= ST_T2;
               state_ff   <= ST_WAIT;
            end
            ST_T2: begin
               ia_ff    <= ia_sum_c;
               state_ff <= ST_NOISE;
            end
            ST_NOISE: begin
               noise_ff <= est_r_c;
               state_ff <= ST_NORM;
            end
            // gain = P'/(P'+R) in Q.F
            ST_NORM: begin
               if (den_c == '0) begin
                  gain_ff    <= '0;
                  mul_req_ff <= '{1'b1, mag_ff, '0};
                  ret_ff     <= ST_DELTA;
               end else begin
                  div_req_ff <= '{1'b1, DVS_BITS'(num_s_c >> 1),
                                  {num_s_c[0], (DVD_BITS-1)'(0)},
                                  den_s_c[DVS_BITS-1:0], ITER_BITS'(GAIN_BITS)};
                  ret_ff     <= ST_GAIN;
               end
               state_ff <= ST_WAIT;
            end
            ST_GAIN: begin
               gain_ff    <= gain_c;
               mul_req_ff <= '{1'b1, mag_ff, EST_BITS'(gain_c)};
               ret_ff     <= ST_DELTA;
               state_ff   <= ST_WAIT;
            end
            ST_DELTA: begin
               est_ff     <= est_upd_c;
               mul_req_ff <= '{1'b1, EST_BITS'(omg_c), pp_ff};
               ret_ff     <= ST_COV;
               state_ff   <= ST_WAIT;
            end
            ST_COV: begin
               cov_ff   <= mulq_c;
               state_ff <= ST_FINISH;
            end
            // congestion avoidance: cut or grow
            ST_RATIO: begin
               if ({(PROD_BITS-EST_BITS)'(0), est_ff} > mul_rsp.prod) begin
                  // 9*cw times the reciprocal of ten
                  cut_ff     <= 1'b1;
                  mul_req_ff <= '{1'b1,
                                  EST_BITS'(({4'd0, cw_ff} << 3) + {4'd0, cw_ff}),
                                  RECIP10};
                  ret_ff     <= ST_CUT;
               end else begin
                  mul_req_ff <= '{1'b1, EST_BITS'(seg_ff), EST_BITS'(seg_ff)};
                  ret_ff     <= ST_GROW;
               end
               state_ff <= ST_WAIT;
            end
            ST_CUT: begin
               ncw_ff   <= mul_rsp.prod[CUT_SHIFT+CW_BITS-1:CUT_SHIFT];
               state_ff <= ST_FINISH;
            end
            ST_GROW: begin
               div_req_ff <= '{1'b1, '0, {mul_rsp.prod[CW_BITS-1:0], 4'd0},
                               DVS_BITS'(cw_div_c), ITER_BITS'(CW_BITS)};
               ret_ff     <= ST_GROW_DIV;
               state_ff   <= ST_WAIT;
            end
            ST_GROW_DIV: begin
               ncw_ff   <= grow_cwnd_c;
               state_ff <= ST_FINISH;
            end
            ST_WAIT: begin
               if (mul_rsp.done || div_rsp.done) begin
                  state_ff <= ret_ff;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_cwnd_ff  <= ncw_ff;
                  rsp_pred_ff  <= est_ff[PRED_BITS-1:0];
                  rsp_base_ff  <= min_ff;
                  rsp_cut_ff   <= cut_ff;
                  rsp_taken_ff <= taken_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_cwnd      = rsp_cwnd_ff;
   assign rsp_predicted_rtt = rsp_pred_ff;
   assign rsp_base_rtt_ms   = rsp_base_ff;
   assign rsp_window_cut    = rsp_cut_ff;
   assign rsp_sample_taken  = rsp_taken_ff;

   // checks
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && div_rsp.done))
      else $error("multiplier and divider finished together");

   a_estimate_floor: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> est_ff >= TENTH_Q)
      else $error("estimate below floor after start");

   a_cut_excl_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_window_cut && rsp_sample_taken))
      else $error("word flagged both cut and sample");

   a_min_set: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> min_ff != '0)
      else $error("filter started without base rtt");

endmodule

// ===== rtl/krwc_mul.sv =====
// ----------------------------------------------------------------------------
// krwc_mul
// Shared 56x56 multiplier: four 28x28 partial products, one per cycle,
// registered and then accumulated into a 112-bit product.
// ----------------------------------------------------------------------------
module krwc_mul import krwc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic [2:0] MUL_STEPS = 3'd4;

   logic [EST_BITS-1:0]  a_ff, b_ff;
   logic [2:0]           cnt_ff;
   logic                 busy_ff, pv_ff, done_ff;
   logic [EST_BITS-1:0]  part_ff, part_in;
   logic [1:0]           sh_ff, sh_in;
   logic [PROD_BITS-1:0] acc_ff, shifted;
   logic [HALF_W-1:0]    a_half, b_half;

   // partial product select and alignment
   always_comb begin
      a_half  = cnt_ff[0] ? a_ff[EST_BITS-1:HALF_W] : a_ff[HALF_W-1:0];
      b_half  = cnt_ff[1] ? b_ff[EST_BITS-1:HALF_W] : b_ff[HALF_W-1:0];
      part_in = EST_BITS'(a_half) * EST_BITS'(b_half);
      sh_in   = 2'(cnt_ff[0]) + 2'(cnt_ff[1]);
      case (sh_ff)
         2'd0:    shifted = PROD_BITS'(part_ff);
         2'd1:    shifted = PROD_BITS'(part_ff) << HALF_W;
         2'd2:    shifted = PROD_BITS'(part_ff) << EST_BITS;
         default: shifted = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            a_ff    <= req.a;
            b_ff    <= req.b;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
            pv_ff   <= 1'b0;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            if (pv_ff) begin
               acc_ff <= acc_ff + shifted;
            end
            if (cnt_ff != MUL_STEPS) begin
               part_ff <= part_in;
               sh_ff   <= sh_in;
               pv_ff   <= 1'b1;
               cnt_ff  <= cnt_ff + 3'd1;
            end else begin
               pv_ff   <= 1'b0;
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

// ===== rtl/krwc_div.sv =====
// ----------------------------------------------------------------------------
// krwc_div
// Shared restoring divider, one quotient bit per cycle. The remainder can
// be preloaded so that a fraction quotient needs only its own bits.
// ----------------------------------------------------------------------------
module krwc_div import krwc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic [DVS_BITS-1:0]  rem_ff, dvs_ff;
   logic [DVD_BITS-1:0]  dvd_ff, quo_ff;
   logic [ITER_BITS-1:0] cnt_ff;
   logic                 busy_ff, done_ff;
   logic [DVS_BITS:0]    trial;
   logic                 ge;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_BITS-1]};
      ge    = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            rem_ff  <= req.rem_init;
            dvd_ff  <= req.dvd;
            dvs_ff  <= req.dvs;
            quo_ff  <= '0;
            cnt_ff  <= req.iters;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? DVS_BITS'(trial - {1'b0, dvs_ff}) : trial[DVS_BITS-1:0];
            dvd_ff <= {dvd_ff[DVD_BITS-2:0], 1'b0};
            quo_ff <= {quo_ff[DVD_BITS-2:0], ge};
            cnt_ff <= cnt_ff - ITER_BITS'(1);
            if (cnt_ff == ITER_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ===== verif/tb_kalman_rtt_window_control.sv =====
// ----------------------------------------------------------------------------
// tb_kalman_rtt_window_control
// Self-checking bench for the RTT window control block. A directed table
// covers reset state, window extremes and filter seeding. Random phases
// follow, one per register setting. Every accepted word is run through a
// local copy of the filter and window logic, and each response word is
// compared field by field in order.
// ----------------------------------------------------------------------------
module tb_kalman_rtt_window_control;
   import krwc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_BITS-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic FUNC_ACK    = 1'b0;
   localparam logic FUNC_WINDOW = 1'b1;
   localparam logic [63:0] UNITY = 64'd1 << FRAC_BITS;
   localparam logic [63:0] TENTH = (UNITY + 64'd5) / 64'd10;
   localparam logic [63:0] CAP   = 64'(CAP56);
   localparam logic [63:0] CW_MAX = 64'hFFFF_FFFF;

   typedef struct packed {
      logic [CW_BITS-1:0]   ncw;
      logic [PRED_BITS-1:0] pred;
      logic [RTT_BITS-1:0]  base;
      logic                 cut;
      logic                 taken;
   } window_result_type;

   typedef struct packed {
      logic                 func;
      logic [RTT_BITS-1:0]  rtt;
      logic [CW_BITS-1:0]   cwnd;
      logic [CW_BITS-1:0]   ssthresh;
      logic [SEG_BITS-1:0]  seg;
      logic                 typed;
      window_result_type    want;
   } stim_row_type;

   logic clock, reset;
   logic req_valid, req_ready, req_func;
   logic [RTT_BITS-1:0] req_rtt_ms;
   logic [CW_BITS-1:0]  req_cwnd, req_ssthresh;
   logic [SEG_BITS-1:0] req_segment_size;
   logic rsp_valid, rsp_ready;
   logic [CW_BITS-1:0]   rsp_new_cwnd;
   logic [PRED_BITS-1:0] rsp_predicted_rtt;
   logic [RTT_BITS-1:0]  rsp_base_rtt_ms;
   logic rsp_window_cut, rsp_sample_taken;
   logic csr_we;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // local copy of registers and filter state
   logic [63:0] m_pnoise, m_inoise, m_adapt, m_alpha, m_ratio;
   logic        m_started;
   logic [63:0] m_est, m_cov, m_noise, m_avg, m_min;

   window_result_type pending_results[$];
   int  fail_count;
   bit  calm;          // no idling on either side while set
   int  rx_stall;
   stim_row_type rows[20];

   kalman_rtt_window_control uut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pause_len();
      int sel;
      sel = $urandom_range(0, 99);
      if (calm || sel < 60) return 0;
      if (sel < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // floor(a*b / 2^F), saturated at 56 bits
   function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      if (p[127:EST_BITS+FRAC_BITS] != '0) return CAP;
      return {8'd0, p[EST_BITS+FRAC_BITS-1:FRAC_BITS]};
   endfunction

   function automatic logic [63:0] cap56(input logic [63:0] v);
      return v > CAP ? CAP : v;
   endfunction

   // one Kalman update on a nonzero sample
   task automatic filter_sample(input logic [63:0] z);
      logic [63:0] zq, pp, mag, delta, gain, num, den, a, est_r;
      logic neg;
      if (m_min == 0 || z < m_min) m_min = z;
      zq = z << FRAC_BITS;
      if (!m_started) begin
         m_est = zq;
         m_noise = m_inoise;
         m_cov = m_noise;
         m_avg = 0;
         m_started = 1'b1;
         return;
      end
      pp = cap56(m_cov + m_pnoise);
      neg = zq < m_est;
      mag = neg ? m_est - zq : zq - m_est;
      if (m_adapt[0]) begin
         a = m_alpha > UNITY ? UNITY : m_alpha;
         m_avg = cap56(qmul(a, qmul(mag, mag)) + qmul(UNITY - a, m_avg));
         est_r = m_avg > pp ? m_avg - pp : 64'd0;
         if (est_r < (UNITY >> 1)) est_r = UNITY >> 1;
         m_noise = est_r;
      end
      num = pp;
      den = pp + m_noise;
      while ((den >> (63 - FRAC_BITS)) != 0) begin
         num = num >> 1;
         den = den >> 1;
      end
      gain = den == 0 ? 64'd0 : (num << FRAC_BITS) / den;
      if (gain > UNITY) gain = UNITY;
      delta = qmul(mag, gain);
      if (neg) m_est = delta > m_est ? 64'd0 : m_est - delta;
      else m_est = cap56(m_est + delta);
      if (m_est < TENTH) m_est = TENTH;
      m_cov = qmul(UNITY - gain, pp);
   endtask

   task automatic predict_word(input stim_row_type w, output window_result_type r);
      logic [63:0] ncw, cw, seg;
      cw = 64'(w.cwnd);
      seg = 64'(w.seg);
      ncw = cw;
      r = '0;
      if (w.func == FUNC_ACK) begin
         if (w.rtt != 0) begin
            filter_sample(64'(w.rtt));
            r.taken = 1'b1;
         end
      end else if (w.cwnd < w.ssthresh) begin
         ncw = cw + seg;
      end else if (m_started && m_min != 0 && m_est > m_ratio * m_min) begin
         ncw = cw * 9 / 10;
         r.cut = 1'b1;
      end else begin
         ncw = cw + (seg * seg) / (cw == 0 ? 64'd1 : cw);
      end
      if (ncw > CW_MAX) ncw = CW_MAX;
      r.ncw = ncw[CW_BITS-1:0];
      r.pred = m_est[PRED_BITS-1:0];
      r.base = m_min[RTT_BITS-1:0];
   endtask

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      fail_count++;
   endtask

   // response side: compare accepted words, random backpressure
   always @(posedge clock) begin
      window_result_type w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected word", 64'(rsp_new_cwnd), 64'd0);
            end else begin
               w = pending_results.pop_front();
               if (rsp_new_cwnd != w.ncw)
                  report_mismatch("new_cwnd", 64'(rsp_new_cwnd), 64'(w.ncw));
               if (rsp_predicted_rtt != w.pred)
                  report_mismatch("predicted_rtt", 64'(rsp_predicted_rtt), 64'(w.pred));
               if (rsp_base_rtt_ms != w.base)
                  report_mismatch("base_rtt_ms", 64'(rsp_base_rtt_ms), 64'(w.base));
               if (rsp_window_cut != w.cut)
                  report_mismatch("window_cut", 64'(rsp_window_cut), 64'(w.cut));
               if (rsp_sample_taken != w.taken)
                  report_mismatch("sample_taken", 64'(rsp_sample_taken), 64'(w.taken));
            end
         end
         if (rx_stall > 0) begin
            rsp_ready <= 1'b0;
            rx_stall <= rx_stall - 1;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) rx_stall <= pause_len();
         end
      end
   end

   // offer one word, hold it until taken, then queue its prediction
   task automatic send_word(input stim_row_type w);
      window_result_type r;
      int gap;
      gap = pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= w.func;
      req_rtt_ms <= w.rtt;
      req_cwnd <= w.cwnd;
      req_ssthresh <= w.ssthresh;
      req_segment_size <= w.seg;
      do @(posedge clock); while (!req_ready);
      predict_word(w, r);
      pending_results.push_back(w.typed ? w.want : r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // one register write; the enable is dropped by the caller
   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input logic [63:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_BITS-1:0];
      @(posedge clock);
      case (idx)
         CSR_PROCESS_NOISE:   m_pnoise = val & 64'hFF_FFFF;
         CSR_INITIAL_NOISE:   m_inoise = val & 64'hFF_FFFF;
         CSR_ADAPTIVE_ENABLE: m_adapt  = val & 64'h1;
         CSR_ADAPT_ALPHA:     m_alpha  = val & 64'h1_FFFF;
         CSR_RATIO_THRESHOLD: m_ratio  = val & 64'h7_FFFF;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [63:0] pn, input logic [63:0] in_n,
                                 input logic [63:0] ae, input logic [63:0] al,
                                 input logic [63:0] rt);
      csr_write(CSR_PROCESS_NOISE, pn);
      csr_write(CSR_INITIAL_NOISE, in_n);
      csr_write(CSR_ADAPTIVE_ENABLE, ae);
      csr_write(CSR_ADAPT_ALPHA, al);
      csr_write(CSR_RATIO_THRESHOLD, rt);
      csr_write(CSR_UNUSED_INDEX, 64'hFF_FFFF);
      csr_we <= 1'b0;
   endtask

   // random word: ACK or window, with the RTT mostly jittering around a path RTT
   function automatic stim_row_type random_word(input int base_rtt);
      stim_row_type w;
      int sel;
      w = '0;
      w.func = 1'($urandom_range(0, 1));
      sel = $urandom_range(0, 99);
      if (sel < 8) w.rtt = '0;
      else if (sel < 80) w.rtt = RTT_BITS'(base_rtt + $urandom_range(0, base_rtt));
      else if (sel < 90) w.rtt = RTT_BITS'($urandom_range(1, 20'hFFFFF));
      else w.rtt = RTT_BITS'($urandom_range(1, base_rtt));
      sel = $urandom_range(0, 9);
      if (sel < 4) w.cwnd = $urandom_range(1000, 200000);
      else if (sel < 8) w.cwnd = $urandom;
      else if (sel < 9) w.cwnd = '0;
      else w.cwnd = '1;
      sel = $urandom_range(0, 3);
      if (sel == 0) w.ssthresh = $urandom;
      else if (sel == 1) w.ssthresh = '0;
      else w.ssthresh = w.cwnd + $urandom_range(0, 3000) - 1500;
      sel = $urandom_range(0, 3);
      if (sel < 2) w.seg = SEG_BITS'($urandom_range(500, 1500));
      else if (sel == 2) w.seg = SEG_BITS'($urandom_range(1, 65535));
      else w.seg = '1;
      return w;
   endfunction

   task automatic random_phase(input int count);
      int base_rtt;
      base_rtt = $urandom_range(5, 2000);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
         send_word(random_word(base_rtt));
      end
      calm = 1'b0;
   endtask

   initial begin
      // reset values of the register copies and filter state
      m_pnoise = 64'd65536; m_inoise = 64'd655360; m_adapt = 64'd1;
      m_alpha = 64'd6554; m_ratio = 64'd81920;
      m_started = 1'b0; m_est = 0; m_cov = 0; m_noise = 0; m_avg = 0; m_min = 0;
      fail_count = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0; req_func = FUNC_ACK; req_rtt_ms = '0; req_cwnd = '0;
      req_ssthresh = '0; req_segment_size = 16'd1;
      csr_we = 1'b0; csr_index = CSR_PROCESS_NOISE; csr_wdata = '0;

      // directed words: func, rtt, cwnd, ssthresh, seg, typed, expected
      rows[0]  = '{FUNC_ACK, 20'd0, 32'd1234, 32'd0, 16'd1, 1'b1,
                   '{32'd1234, 36'd0, 20'd0, 1'b0, 1'b0}};
      rows[1]  = '{FUNC_WINDOW, 20'd0, 32'd100, 32'd1000, 16'd10, 1'b1,
                   '{32'd110, 36'd0, 20'd0, 1'b0, 1'b0}};
      rows[2]  = '{FUNC_WINDOW, 20'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
                   '{32'hFFFF_FFFF, 36'd0, 20'd0, 1'b0, 1'b0}};
      rows[3]  = '{FUNC_WINDOW, 20'd0, 32'd0, 32'd0, 16'hFFFF, 1'b1,
                   '{32'hFFFE_0001, 36'd0, 20'd0, 1'b0, 1'b0}};
      rows[4]  = '{FUNC_WINDOW, 20'd0, 32'hFFFF_FFFF, 32'd0, 16'd1, 1'b1,
                   '{32'hFFFF_FFFF, 36'd0, 20'd0, 1'b0, 1'b0}};
      rows[5]  = '{FUNC_ACK, 20'd100, 32'd5000, 32'd0, 16'd1, 1'b1,
                   '{32'd5000, 36'h64_0000, 20'd100, 1'b0, 1'b1}};
      rows[6]  = '{FUNC_ACK, 20'd0, 32'd7, 32'd0, 16'd1, 1'b0, '0};
      rows[7]  = '{FUNC_ACK, 20'd120, 32'd7, 32'd0, 16'd1, 1'b0, '0};
      rows[8]  = '{FUNC_ACK, 20'd300, 32'd7, 32'd0, 16'd1, 1'b0, '0};
      rows[9]  = '{FUNC_WINDOW, 20'd0, 32'd20000, 32'd10000, 16'd1460, 1'b0, '0};
      rows[10] = '{FUNC_ACK, 20'hFFFFF, 32'd0, 32'd0, 16'd1, 1'b0, '0};
      rows[11] = '{FUNC_ACK, 20'hFFFFF, 32'd0, 32'd0, 16'd1, 1'b0, '0};
      rows[12] = '{FUNC_WINDOW, 20'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 1'b0, '0};
      rows[13] = '{FUNC_ACK, 20'd1, 32'd0, 32'd0, 16'd1, 1'b0, '0};
      rows[14] = '{FUNC_ACK, 20'd1, 32'd0, 32'd0, 16'd1, 1'b0, '0};
      rows[15] = '{FUNC_ACK, 20'd1, 32'd0, 32'd0, 16'd1, 1'b0, '0};
      rows[16] = '{FUNC_ACK, 20'd1, 32'd0, 32'd0, 16'd1, 1'b0, '0};
      rows[17] = '{FUNC_WINDOW, 20'd0, 32'd0, 32'd0, 16'd3, 1'b0, '0};
      rows[18] = '{FUNC_WINDOW, 20'd0, 32'd7, 32'd0, 16'd3, 1'b0, '0};
      rows[19] = '{FUNC_WINDOW, 20'd0, 32'd1000, 32'd1000, 16'd500, 1'b0, '0};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) send_word(rows[i]);
      wait_idle();

      // register sweeps, each followed by a random phase
      apply_settings(64'd0, 64'd66, 64'd0, 64'd0, 64'd65536);
      random_phase(250);
      wait_idle();
      apply_settings(64'hFF_FFFF, 64'hFF_FFFF, 64'd1, 64'd65536, 64'd262144);
      random_phase(250);
      wait_idle();
      apply_settings(64'($urandom_range(0, 24'hFF_FFFF)),
                     64'($urandom_range(66, 24'hFF_FFFF)),
                     64'd1, 64'h1_FFFF, 64'($urandom_range(65536, 262144)));
      random_phase(250);
      wait_idle();
      apply_settings(64'd65536, 64'd655360, 64'd1, 64'd0, 64'd81920);
      random_phase(250);
      wait_idle();
      apply_settings(64'($urandom_range(0, 24'hFF_FFFF)),
                     64'($urandom_range(66, 24'hFF_FFFF)),
                     64'($urandom_range(0, 1)), 64'($urandom_range(0, 65536)),
                     64'($urandom_range(65536, 262144)));
      random_phase(250);
      wait_idle();

      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
